>>> rtl/core/barf_pkg.sv
// ----------------------------------------------------------------------------
// barf_pkg : shared types and constants for the advertising record filter
// Request and response payload structs, register indexes and field codes.
// ----------------------------------------------------------------------------
package barf_pkg;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_ENABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_CHANNEL = 1'd1;

   // AD structure type codes
   localparam logic [7:0] AD_NAME_SHORT = 8'h08;
   localparam logic [7:0] AD_NAME_FULL  = 8'h09;
   localparam logic [7:0] AD_MANUF      = 8'hFF;

   // manufacturer magic FF FF AB CD
   localparam logic [7:0] MAGIC_0 = 8'hFF;
   localparam logic [7:0] MAGIC_1 = 8'hFF;
   localparam logic [7:0] MAGIC_2 = 8'hAB;
   localparam logic [7:0] MAGIC_3 = 8'hCD;

   localparam logic [7:0] NAME_MAX       = 8'd31;
   localparam logic [7:0] CHANNEL_OFFSET = 8'd4;
   localparam logic [7:0] MIN_RECORD_LEN = 8'd16;
   localparam logic [7:0] MIN_MAGIC_LEN  = 8'd4;

   // result kinds
   localparam logic KIND_NAME    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] bytes_after;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] name_char;
      logic       name_end;
      logic       record_accepted;
      logic [7:0] record_channel;
      logic       malformed;
      logic       last;
   } rsp_type;

endpackage

>>> rtl/core/ble_adv_record_filter_core.sv
// ----------------------------------------------------------------------------
// ble_adv_record_filter_core : advertising data record filter
// Walks the length-type-data structures of an advertising payload, emits
// device name characters and reports a keyboard record summary per packet.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one payload byte per request with the count of bytes still to
//    come; bytes_after of zero marks the last byte of a packet.
//  - rsp_*: name characters (kind 0) and one summary per packet (kind 1);
//    last marks the final response caused by a request.
//  - csr_*: register writes, always ready; write only while idle.
//  - Each request is decoded in the cycle it is accepted; its responses
//    enter a four-entry registered response queue that feeds rsp_*.
//  - Throughput: one request per cycle while req_stall is low. A request makes
//    at most two responses; req_stall rises while the queue holds more than
//    two, so a run of bytes that each finish a name and a packet goes at the
//    output rate of one response per cycle while rsp_stall is low.
//  - rsp_stall holds the queue head; requests keep flowing until the queue
//    holds more than two entries.
//  - Reset: scanning disabled, own channel zero, packet state cleared, queue
//    empty. With scanning disabled requests are taken and dropped.
// ----------------------------------------------------------------------------
module ble_adv_record_filter_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  barf_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output barf_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [barf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [7:0]                         csr_wdata
);

   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,
      PH_TYPE = 2'd1,
      PH_DATA = 2'd2,
      PH_STOP = 2'd3
   } phase_type;

   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QAW    = $clog2(QDEPTH);
   localparam int unsigned QCW    = $clog2(QDEPTH + 1);

   // configuration
   logic       scan_enable_ff;
   logic [7:0] own_channel_ff;

   // packet walk state
   phase_type  phase_ff, phase_in;
   logic [7:0] field_left_ff, field_left_in;
   logic [7:0] field_kind_ff, field_kind_in;
   logic [7:0] field_pos_ff, field_pos_in;
   logic [7:0] field_len_ff, field_len_in;
   logic       magic_good_ff, magic_good_in;
   logic [7:0] seen_channel_ff, seen_channel_in;
   logic       accepted_flag_ff, accepted_flag_in;
   logic [7:0] accepted_channel_ff, accepted_channel_in;
   logic       stop_flag_ff, stop_flag_in;

   // response queue
   barf_pkg::rsp_type q_ff [QDEPTH];
   logic [QAW-1:0]    head_ff, tail_ff;
   logic [QCW-1:0]    count_ff;

   logic              req_take, rsp_take;
   logic              emit_name, emit_sum;
   logic [7:0]        name_lim, left_dec;
   logic              is_name;
   logic              pass_now;
   logic [7:0]        pass_channel;
   barf_pkg::rsp_type name_rsp, sum_rsp, wr0, wr1;
   logic [1:0]        n_push;

   assign req_stall = (count_ff > QCW'(QDEPTH - 2));
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign rsp_data  = q_ff[head_ff];
   assign csr_ready = 1'b1;

   assign is_name  = (field_kind_ff == barf_pkg::AD_NAME_SHORT) ||
                     (field_kind_ff == barf_pkg::AD_NAME_FULL);
   assign name_lim = (field_len_ff < barf_pkg::NAME_MAX) ? field_len_ff
                                                          : barf_pkg::NAME_MAX;
   assign left_dec = field_left_ff - 8'd1;

   always_comb begin
      phase_in            = phase_ff;
      field_left_in       = field_left_ff;
      field_kind_in       = field_kind_ff;
      field_pos_in        = field_pos_ff;
      field_len_in        = field_len_ff;
      magic_good_in       = magic_good_ff;
      seen_channel_in     = seen_channel_ff;
      accepted_flag_in    = accepted_flag_ff;
      accepted_channel_in = accepted_channel_ff;
      stop_flag_in        = stop_flag_ff;
      emit_name           = 1'b0;
      emit_sum            = 1'b0;
      pass_now            = 1'b0;
      pass_channel        = 8'd0;

      case (phase_ff)
         PH_LEN: begin
            if (req_data.bytes_after == 8'd0) begin
               // lone trailing byte: stop, not malformed
               phase_in = PH_STOP;
               stop_flag_in = 1'b0;
            end else if (req_data.data_byte == 8'd0 ||
                         req_data.data_byte > req_data.bytes_after) begin
               phase_in = PH_STOP;
               stop_flag_in = 1'b1;
            end else begin
               field_left_in = req_data.data_byte;
               phase_in = PH_TYPE;
            end
         end
         PH_TYPE: begin
            field_kind_in   = req_data.data_byte;
            field_len_in    = left_dec;
            field_left_in   = left_dec;
            field_pos_in    = 8'd0;
            magic_good_in   = 1'b0;
            seen_channel_in = 8'd0;
            phase_in        = (left_dec == 8'd0) ? PH_LEN : PH_DATA;
         end
         PH_DATA: begin
            if (is_name) begin
               emit_name = (field_pos_ff < name_lim);
            end else if (field_kind_ff == barf_pkg::AD_MANUF) begin
               case (field_pos_ff)
                  8'd0: magic_good_in = (req_data.data_byte == barf_pkg::MAGIC_0);
                  8'd1: magic_good_in = magic_good_ff &&
                                        (req_data.data_byte == barf_pkg::MAGIC_1);
                  8'd2: magic_good_in = magic_good_ff &&
                                        (req_data.data_byte == barf_pkg::MAGIC_2);
                  8'd3: magic_good_in = magic_good_ff &&
                                        (req_data.data_byte == barf_pkg::MAGIC_3);
                  default: magic_good_in = magic_good_ff;
               endcase
               if (field_pos_ff == barf_pkg::CHANNEL_OFFSET &&
                   field_len_ff > barf_pkg::CHANNEL_OFFSET) begin
                  seen_channel_in = req_data.data_byte;
               end
            end
            field_pos_in  = field_pos_ff + 8'd1;
            field_left_in = left_dec;
            if (left_dec == 8'd0) begin
               // field complete: keyboard record decision
               if (field_kind_ff == barf_pkg::AD_MANUF && magic_good_in &&
                   field_len_ff >= barf_pkg::MIN_MAGIC_LEN &&
                   field_len_ff >= barf_pkg::MIN_RECORD_LEN &&
                   (own_channel_ff == 8'd0 || own_channel_ff == seen_channel_in)) begin
                  accepted_flag_in    = 1'b1;
                  accepted_channel_in = seen_channel_in;
                  pass_now            = 1'b1;
                  pass_channel        = seen_channel_in;
               end
               phase_in = PH_LEN;
            end
         end
         default: ;
      endcase

      emit_sum = (req_data.bytes_after == 8'd0);

      // packet end or scanning off: back to a fresh packet
      if (!scan_enable_ff || emit_sum) begin
         phase_in            = PH_LEN;
         field_left_in       = 8'd0;
         field_kind_in       = 8'd0;
         field_pos_in        = 8'd0;
         field_len_in        = 8'd0;
         magic_good_in       = 1'b0;
         seen_channel_in     = 8'd0;
         accepted_flag_in    = 1'b0;
         accepted_channel_in = 8'd0;
         stop_flag_in        = 1'b0;
      end
      if (!scan_enable_ff) begin
         emit_name = 1'b0;
         emit_sum  = 1'b0;
      end
   end

   // summary reports the state as updated by this byte, before clearing
   always_comb begin
      name_rsp                  = '0;
      name_rsp.kind             = barf_pkg::KIND_NAME;
      name_rsp.name_char        = req_data.data_byte;
      name_rsp.name_end         = (field_pos_ff + 8'd1 == name_lim);
      name_rsp.last             = !emit_sum;

      sum_rsp                   = '0;
      sum_rsp.kind              = barf_pkg::KIND_SUMMARY;
      sum_rsp.malformed         = (phase_ff == PH_LEN) &&
                                  (req_data.bytes_after != 8'd0) ? 1'b0 :
                                  (phase_ff == PH_STOP) ? stop_flag_ff : 1'b0;
      sum_rsp.last              = 1'b1;

      sum_rsp.record_accepted   = accepted_flag_ff || pass_now;
      sum_rsp.record_channel    = pass_now ? pass_channel : accepted_channel_ff;
      if (!sum_rsp.record_accepted)
         sum_rsp.record_channel = 8'd0;

      wr0    = emit_name ? name_rsp : sum_rsp;
      wr1    = sum_rsp;
      n_push = {1'b0, emit_name} + {1'b0, emit_sum};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_enable_ff      <= 1'b0;
         own_channel_ff      <= 8'd0;
         phase_ff            <= PH_LEN;
         field_left_ff       <= 8'd0;
         field_kind_ff       <= 8'd0;
         field_pos_ff        <= 8'd0;
         field_len_ff        <= 8'd0;
         magic_good_ff       <= 1'b0;
         seen_channel_ff     <= 8'd0;
         accepted_flag_ff    <= 1'b0;
         accepted_channel_ff <= 8'd0;
         stop_flag_ff        <= 1'b0;
         head_ff             <= '0;
         tail_ff             <= '0;
         count_ff            <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               barf_pkg::CSR_SCAN_ENABLE: scan_enable_ff <= csr_wdata[0];
               barf_pkg::CSR_OWN_CHANNEL: own_channel_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req_take) begin
            phase_ff            <= phase_in;
            field_left_ff       <= field_left_in;
            field_kind_ff       <= field_kind_in;
            field_pos_ff        <= field_pos_in;
            field_len_ff        <= field_len_in;
            magic_good_ff       <= magic_good_in;
            seen_channel_ff     <= seen_channel_in;
            accepted_flag_ff    <= accepted_flag_in;
            accepted_channel_ff <= accepted_channel_in;
            stop_flag_ff        <= stop_flag_in;
            tail_ff             <= tail_ff + QAW'(n_push);
         end
         if (rsp_take)
            head_ff <= head_ff + QAW'(1);
         count_ff <= count_ff + (req_take ? QCW'(n_push) : QCW'(0))
                              - (rsp_take ? QCW'(1) : QCW'(0));
      end
   end

   // queue payload, no reset
   always_ff @(posedge clock) begin
      if (req_take && n_push != 2'd0)
         q_ff[tail_ff] <= wr0;
      if (req_take && n_push == 2'd2)
         q_ff[tail_ff + QAW'(1)] <= wr1;
   end

   // ---------------------------------------------------------------------
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCW'(QDEPTH))
      else $error("response queue over depth");

   a_stop_flag_only_stopped : assert property (@(posedge clock) disable iff (reset)
      stop_flag_ff |-> phase_ff == PH_STOP)
      else $error("malformed flag outside stopped walk");

   a_packet_end_clears : assert property (@(posedge clock) disable iff (reset)
      req_take && req_data.bytes_after == 8'd0 |=>
         phase_ff == PH_LEN && !accepted_flag_ff && !stop_flag_ff)
      else $error("packet state not cleared at packet end");

   a_disabled_no_push : assert property (@(posedge clock) disable iff (reset)
      req_take && !scan_enable_ff && !rsp_take |=> $stable(count_ff))
      else $error("response produced while scanning disabled");

   a_stall_holds_head : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(head_ff))
      else $error("queue head moved under stall");

endmodule

>>> tb/barf_rsp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// barf_rsp_checker : response checker for the advertising record filter
// Follows register writes, runs every accepted request through its own
// AD structure walker and matches each response in order, field by field.
// ----------------------------------------------------------------------------
module barf_rsp_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  barf_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  barf_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [barf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_wdata,
   output int                             mismatches,
   output int                             outstanding
);

   typedef enum logic [1:0] {WALK_LEN, WALK_TYPE, WALK_DATA, WALK_STOP} walk_type;

   logic       scan_en;
   logic [7:0] own_ch;

   walk_type   walk;
   logic [7:0] left;
   logic [7:0] ad_type;
   logic [7:0] pos;
   logic [7:0] data_len;
   logic       magic_ok;
   logic [7:0] seen_ch;
   logic       acc_flag;
   logic [7:0] acc_ch;
   logic       bad_len;

   barf_pkg::rsp_type pending_rsp[$];
   int                err_count = 0;

   task automatic clear_walk();
      walk     = WALK_LEN;
      left     = '0;
      ad_type  = '0;
      pos      = '0;
      data_len = '0;
      magic_ok = 1'b0;
      seen_ch  = '0;
      acc_flag = 1'b0;
      acc_ch   = '0;
      bad_len  = 1'b0;
   endtask

   // walk one payload byte and queue the responses it should cause
   task automatic decode_byte(input barf_pkg::req_type r);
      barf_pkg::rsp_type res[2];
      int                n;
      logic [7:0]        lim;
      logic [7:0]        b;
      logic [7:0]        after;
      n     = 0;
      b     = r.data_byte;
      after = r.bytes_after;
      if (!scan_en) begin
         clear_walk();
         return;
      end
      case (walk)
         WALK_LEN: begin
            if (after == 0) begin
               // lone trailing byte: stop, but not malformed
               walk    = WALK_STOP;
               bad_len = 1'b0;
            end else if (b == 0 || b > after) begin
               walk    = WALK_STOP;
               bad_len = 1'b1;
            end else begin
               left = b;
               walk = WALK_TYPE;
            end
         end
         WALK_TYPE: begin
            ad_type  = b;
            data_len = left - 8'd1;
            left     = data_len;
            pos      = '0;
            magic_ok = 1'b0;
            seen_ch  = '0;
            walk     = (left == 0) ? WALK_LEN : WALK_DATA;
         end
         WALK_DATA: begin
            if (ad_type == barf_pkg::AD_NAME_SHORT || ad_type == barf_pkg::AD_NAME_FULL) begin
               lim = (data_len < barf_pkg::NAME_MAX) ? data_len : barf_pkg::NAME_MAX;
               if (pos < lim) begin
                  res[n]           = '0;
                  res[n].kind      = barf_pkg::KIND_NAME;
                  res[n].name_char = b;
                  res[n].name_end  = (pos + 8'd1 == lim);
                  n++;
               end
            end else if (ad_type == barf_pkg::AD_MANUF) begin
               case (pos)
                  8'd0: magic_ok = (b == barf_pkg::MAGIC_0);
                  8'd1: magic_ok = magic_ok && (b == barf_pkg::MAGIC_1);
                  8'd2: magic_ok = magic_ok && (b == barf_pkg::MAGIC_2);
                  8'd3: magic_ok = magic_ok && (b == barf_pkg::MAGIC_3);
                  default: ;
               endcase
               if (pos == barf_pkg::CHANNEL_OFFSET && data_len > barf_pkg::CHANNEL_OFFSET)
                  seen_ch = b;
            end
            pos  = pos + 8'd1;
            left = left - 8'd1;
            if (left == 0) begin
               // an earlier acceptance survives a later failing record
               if (ad_type == barf_pkg::AD_MANUF && magic_ok &&
                   data_len >= barf_pkg::MIN_MAGIC_LEN &&
                   data_len >= barf_pkg::MIN_RECORD_LEN &&
                   (own_ch == 0 || own_ch == seen_ch)) begin
                  acc_flag = 1'b1;
                  acc_ch   = seen_ch;
               end
               walk = WALK_LEN;
            end
         end
         default: ;
      endcase
      if (after == 0) begin
         res[n]                 = '0;
         res[n].kind            = barf_pkg::KIND_SUMMARY;
         res[n].record_accepted = acc_flag;
         res[n].record_channel  = acc_flag ? acc_ch : 8'd0;
         res[n].malformed       = bad_len;
         n++;
         clear_walk();
      end
      if (n > 0)
         res[n-1].last = 1'b1;
      for (int i = 0; i < n; i++)
         pending_rsp.push_back(res[i]);
   endtask

   task automatic match_response(input barf_pkg::rsp_type got);
      barf_pkg::rsp_type want;
      if (pending_rsp.size() == 0) begin
         err_count++;
         if (err_count <= 10)
            $display("%0t: response %h with none expected", $realtime, got);
         return;
      end
      want = pending_rsp.pop_front();
      if (got !== want) begin
         err_count++;
         if (err_count <= 10)
            $display({"%0t: mismatch exp kind %0d char %h end %0d acc %0d ch %h bad %0d",
                      " last %0d / got kind %0d char %h end %0d acc %0d ch %h bad %0d",
                      " last %0d"}, $realtime,
                     want.kind, want.name_char, want.name_end, want.record_accepted,
                     want.record_channel, want.malformed, want.last,
                     got.kind, got.name_char, got.name_end, got.record_accepted,
                     got.record_channel, got.malformed, got.last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scan_en = 1'b0;
         own_ch  = '0;
         clear_walk();
         pending_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            match_response(rsp_data);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               barf_pkg::CSR_SCAN_ENABLE: scan_en = csr_wdata[0];
               barf_pkg::CSR_OWN_CHANNEL: own_ch  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            decode_byte(req_data);
      end
      outstanding <= pending_rsp.size();
      mismatches  <= err_count;
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : testbench for ble_adv_record_filter_core
// Feeds directed and random advertising payloads under several register
// settings, with random gaps and stalls; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   barf_pkg::req_type              req_data  = '0;
   logic                           rsp_stall = 1'b0;
   logic                           csr_valid = 1'b0;
   logic [barf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]                     csr_wdata = '0;
   logic                           req_stall;
   logic                           rsp_valid;
   barf_pkg::rsp_type              rsp_data;
   logic                           csr_ready;
   int                             mismatches;
   int                             outstanding;

   bit                             idle_on      = 1'b0;
   bit                             hold_request = 1'b0;
   logic [7:0]                     own_shadow   = '0;
   int                             offered      = 0;
   logic [7:0]                     pkt[$];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   ble_adv_record_filter_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   barf_rsp_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // one request per call; valid stays up between back-to-back requests
   task automatic send_byte(input logic [7:0] b, input logic [7:0] after);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {b, after};
      do @(posedge clock); while (req_stall);
      offered++;
   endtask

   // cut drops the tail, so the packet may end inside a field
   task automatic send_packet(input bit cut);
      int n;
      n = pkt.size();
      if (cut && n > 1)
         n = $urandom_range(1, n - 1);
      for (int i = 0; i < n; i++)
         send_byte(pkt[i], 8'(n - 1 - i));
      pkt.delete();
   endtask

   task automatic add_field(input logic [7:0] ad, input int dlen);
      pkt.push_back(8'(dlen + 1));
      pkt.push_back(ad);
      repeat (dlen) pkt.push_back(8'($urandom));
   endtask

   task automatic add_manuf(input int dlen);
      logic [7:0] d;
      int         bad_pos;
      bad_pos = ($urandom_range(0, 6) == 0) ? int'($urandom_range(0, 3)) : -1;
      pkt.push_back(8'(dlen + 1));
      pkt.push_back(barf_pkg::AD_MANUF);
      for (int i = 0; i < dlen; i++) begin
         case (i)
            0: d = barf_pkg::MAGIC_0;
            1: d = barf_pkg::MAGIC_1;
            2: d = barf_pkg::MAGIC_2;
            3: d = barf_pkg::MAGIC_3;
            4: begin
               case ($urandom_range(0, 5))
                  0, 1, 2: d = (own_shadow != 0) ? own_shadow : 8'($urandom);
                  3:       d = 8'h00;
                  4:       d = 8'hFF;
                  default: d = 8'($urandom);
               endcase
            end
            default: d = 8'($urandom);
         endcase
         if (i == bad_pos)
            d = d ^ 8'($urandom_range(1, 255));
         pkt.push_back(d);
      end
   endtask

   // wait for every response, then go on waiting so dropped requests clear
   task automatic settle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_config(input logic scan, input logic [7:0] own);
      own_shadow = own;
      csr_valid <= 1'b1;
      csr_index <= barf_pkg::CSR_SCAN_ENABLE;
      csr_wdata <= {7'd0, scan};
      do @(posedge clock); while (!csr_ready);
      csr_index <= barf_pkg::CSR_OWN_CHANNEL;
      csr_wdata <= own;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic scan, input logic [7:0] own, input int items,
                            input bit idling, input bit with_hold);
      int start;
      int pick;
      int len;
      settle();
      write_config(scan, own);
      idle_on = idling;
      if (with_hold)
         hold_request = 1'b1;
      start = offered;
      while (offered - start < items) begin
         if (idling)
            idle_on = ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 99);
         if (pick >= 94) begin
            // noise, sometimes closed by a packet end
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 8'($urandom));
            if ($urandom_range(0, 1) == 0)
               send_byte(8'($urandom), 8'h00);
         end else begin
            if ($urandom_range(0, 29) == 0)
               add_manuf($urandom_range(100, 220));
            else begin
               repeat ($urandom_range(1, 4)) begin
                  case ($urandom_range(0, 9))
                     0, 1, 2, 3:
                        add_field(($urandom_range(0, 1) != 0) ? barf_pkg::AD_NAME_FULL
                                                              : barf_pkg::AD_NAME_SHORT,
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(28, 40)
                                                              : $urandom_range(0, 8));
                     4, 5, 6, 7: begin
                        case ($urandom_range(0, 7))
                           0:       add_manuf($urandom_range(0, 5));
                           1:       add_manuf(15);
                           2:       add_manuf(16);
                           3:       add_manuf(17);
                           default: add_manuf($urandom_range(16, 24));
                        endcase
                     end
                     default: add_field(8'($urandom), $urandom_range(0, 6));
                  endcase
               end
            end
            if (pick >= 80 && pick < 87) begin
               case ($urandom_range(0, 2))
                  0: pkt.push_back(8'($urandom));
                  1: begin
                     pkt.push_back(8'h00);
                     repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
                  end
                  default: begin
                     // length longer than what is left of the packet
                     len = $urandom_range(2, 255);
                     pkt.push_back(8'(len));
                     repeat ($urandom_range(0, (len - 2 < 5) ? len - 2 : 5))
                        pkt.push_back(8'($urandom));
                  end
               endcase
            end
            send_packet(pick >= 87);
         end
      end
   endtask

   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (64) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // scanning still off after reset: these are dropped
      send_byte(8'h02, 8'h05);
      send_byte(8'h30, 8'h04);
      settle();
      write_config(1'b1, 8'h00);
      pkt = '{8'hFF};
      send_packet(1'b0);
      pkt = '{8'h00, 8'h00};
      send_packet(1'b0);
      pkt = '{8'h05, 8'hAB};
      send_packet(1'b0);
      pkt = '{8'h02, barf_pkg::AD_NAME_FULL, 8'h41, 8'h01, barf_pkg::AD_NAME_SHORT, 8'h00};
      send_packet(1'b0);
      pkt = '{8'h05, barf_pkg::AD_MANUF, barf_pkg::MAGIC_0, barf_pkg::MAGIC_1,
              barf_pkg::MAGIC_2, barf_pkg::MAGIC_3};
      send_packet(1'b0);
      // length runs past the packet end, so the walk stops as malformed
      pkt = '{8'h06, barf_pkg::AD_NAME_FULL, 8'h61, 8'h62};
      send_packet(1'b0);

      run_phase(1'b1, 8'h00, 215, 1'b1, 1'b0);
      run_phase(1'b1, 8'hFF, 215, 1'b1, 1'b1);
      run_phase(1'b0, 8'h01, 30, 1'b1, 1'b0);
      run_phase(1'b1, 8'($urandom_range(1, 254)), 215, 1'b1, 1'b0);
      run_phase(1'b1, 8'h01, 215, 1'b1, 1'b1);
      run_phase(1'b1, 8'h00, 215, 1'b1, 1'b0);
      run_phase(1'b1, 8'($urandom_range(1, 254)), 205, 1'b1, 1'b0);
      run_phase(1'b1, 8'h00, 205, 1'b0, 1'b0);
      settle();
      if (mismatches == 0 && outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
